@@ rtl/mpe_pkg.sv @@
`default_nettype none

package mpe_pkg;

    // Image and number format
    localparam int IMAGE_DIM = 4096;
    localparam int FRAC_BITS = 28;

    localparam int WORD_W  = 32;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int WIDE_W  = PROD_W + 1;
    localparam int IDX_W   = 12;
    localparam int STEP_W  = 31;
    localparam int COUNT_W = 16;
    localparam int GREY_W  = 8;

    // Grey level scale: count * 255 needs COUNT_W + GREY_W bits
    localparam int DIVD_W = COUNT_W + GREY_W;
    localparam logic [GREY_W-1:0] GREY_MAX = {GREY_W{1'b1}};

    // APB register map, one 32-bit word per register
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_MAX_ITER    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REAL_ORIGIN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_IMAG_ORIGIN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REAL_STEP   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_IMAG_STEP   = 3'd4;

    // Register values after reset
    localparam logic [COUNT_W-1:0]       RST_MAX_ITER    = 16'd256;
    localparam logic signed [WORD_W-1:0] RST_REAL_ORIGIN = -32'sd536870912;
    localparam logic signed [WORD_W-1:0] RST_IMAG_ORIGIN = -32'sd402653184;
    localparam logic [STEP_W-1:0]        RST_REAL_STEP   = 31'd786432;
    localparam logic [STEP_W-1:0]        RST_IMAG_STEP   = 31'd786432;

    // Escape test: |z|^2 > 4 in a format with 2*FRAC_BITS fraction bits.
    // When the limit does not fit in 64 bits no point can ever escape.
    localparam int ESC_EXP = 2 * FRAC_BITS + 2;
    localparam logic ESC_ON = (ESC_EXP < PROD_W);
    localparam logic [WIDE_W-1:0] ESC_LIMIT =
        ESC_ON ? ({{PROD_W{1'b0}}, 1'b1} << ESC_EXP) : '0;

    // Saturation bounds of a signed word, held at the wide width
    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(WORD_MAX);
    localparam logic signed [WIDE_W-1:0] SAT_LO = WIDE_W'(WORD_MIN);

    typedef struct packed {
        logic [COUNT_W-1:0]       max_iterations;
        logic signed [WORD_W-1:0] real_origin;
        logic signed [WORD_W-1:0] imag_origin;
        logic [STEP_W-1:0]        real_step;
        logic [STEP_W-1:0]        imag_step;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] max_iter;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [GREY_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic [GREY_W-1:0]  grey;
    } t_result;

    // Clamp a wide signed sum to the signed word range.
    function automatic logic signed [WORD_W-1:0] sat_word(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WORD_W-1:0] r;
        if (v > SAT_HI) begin
            r = WORD_MAX;
        end else if (v < SAT_LO) begin
            r = WORD_MIN;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mpe_pix_if.sv @@
`default_nettype none

interface mpe_pix_if;
    import mpe_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink (input valid, input column, input row, output ready);
endinterface

`default_nettype wire

@@ rtl/mpe_res_if.sv @@
`default_nettype none

interface mpe_res_if;
    import mpe_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] iteration_count;
    logic [GREY_W-1:0]  grey_level;

    modport source (output valid, output iteration_count, output grey_level, input ready);
    modport sink (input valid, input iteration_count, input grey_level, output ready);
endinterface

`default_nettype wire

@@ rtl/mpe_cfg.sv @@
`default_nettype none

module mpe_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mpe_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [mpe_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mpe_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready,
    output mpe_pkg::t_cfg                          o_cfg
);
    import mpe_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[APB_ADDR_W-1:2];

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_iterations <= RST_MAX_ITER;
            r_cfg.real_origin    <= RST_REAL_ORIGIN;
            r_cfg.imag_origin    <= RST_IMAG_ORIGIN;
            r_cfg.real_step      <= RST_REAL_STEP;
            r_cfg.imag_step      <= RST_IMAG_STEP;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MAX_ITER:    r_cfg.max_iterations <= pwdata[COUNT_W-1:0];
                REG_REAL_ORIGIN: r_cfg.real_origin    <= pwdata[WORD_W-1:0];
                REG_IMAG_ORIGIN: r_cfg.imag_origin    <= pwdata[WORD_W-1:0];
                REG_REAL_STEP:   r_cfg.real_step      <= pwdata[STEP_W-1:0];
                REG_IMAG_STEP:   r_cfg.imag_step      <= pwdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read data returns the stored value; unmapped addresses read zero.
    always_comb begin
        unique case (w_idx)
            REG_MAX_ITER:    prdata = APB_DATA_W'(r_cfg.max_iterations);
            REG_REAL_ORIGIN: prdata = APB_DATA_W'(r_cfg.real_origin);
            REG_IMAG_ORIGIN: prdata = APB_DATA_W'(r_cfg.imag_origin);
            REG_REAL_STEP:   prdata = APB_DATA_W'(r_cfg.real_step);
            REG_IMAG_STEP:   prdata = APB_DATA_W'(r_cfg.imag_step);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/mpe_mul.sv @@
`default_nettype none

module mpe_mul (
    input  wire logic                                 i_clk,
    input  wire logic signed [mpe_pkg::WORD_W-1:0]    i_a,
    input  wire logic signed [mpe_pkg::WORD_W-1:0]    i_b,
    output logic signed [mpe_pkg::PROD_W-1:0]         o_prod
);
    import mpe_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // Signed word multiplier with a registered full-width product.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ rtl/mpe_div.sv @@
`default_nettype none

module mpe_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mpe_pkg::t_div_req     i_req,
    output mpe_pkg::t_div_rsp          o_rsp
);
    import mpe_pkg::*;

    localparam int STEP_CNT_W = $clog2(GREY_W);

    logic                  r_run;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_step;
    logic [DIVD_W-1:0]     r_rem;
    logic [DIVD_W-1:0]     r_dvs;
    logic [GREY_W-1:0]     r_quot;
    logic                  w_fit;

    assign w_fit = (r_rem >= r_dvs);

    // Control: eight restoring steps, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + STEP_CNT_W'(1);
                if (r_step == STEP_CNT_W'(GREY_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend is count * 255, divisor starts at max << 7.
    // Since count never exceeds max, the quotient fits in eight bits.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {i_req.count, {GREY_W{1'b0}}} - DIVD_W'(i_req.count);
            r_dvs  <= DIVD_W'(i_req.max_iter) << (GREY_W - 1);
            r_quot <= '0;
        end else if (r_run) begin
            if (w_fit) begin
                r_rem <= r_rem - r_dvs;
            end
            r_quot <= {r_quot[GREY_W-2:0], w_fit};
            r_dvs  <= r_dvs >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire

@@ rtl/mpe_core.sv @@
`default_nettype none

module mpe_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mpe_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_start,
    input  wire logic [mpe_pkg::IDX_W-1:0]     i_column,
    input  wire logic [mpe_pkg::IDX_W-1:0]     i_row,
    input  wire logic                          i_take,
    output logic                               o_idle,
    output mpe_pkg::t_result                   o_res
);
    import mpe_pkg::*;

    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
    localparam logic [STATE_W-1:0] S_WRAP   = 4'd1;
    localparam logic [STATE_W-1:0] S_CR_MUL = 4'd2;
    localparam logic [STATE_W-1:0] S_CI_MUL = 4'd3;
    localparam logic [STATE_W-1:0] S_CI_ADD = 4'd4;
    localparam logic [STATE_W-1:0] S_RR     = 4'd5;
    localparam logic [STATE_W-1:0] S_II     = 4'd6;
    localparam logic [STATE_W-1:0] S_RI     = 4'd7;
    localparam logic [STATE_W-1:0] S_UPD    = 4'd8;
    localparam logic [STATE_W-1:0] S_DIV    = 4'd9;
    localparam logic [STATE_W-1:0] S_DONE   = 4'd10;

    localparam logic [IDX_W-1:0] IMG_SUB = IDX_W'(IMAGE_DIM);

    logic [STATE_W-1:0]       r_state;
    logic [STATE_W-1:0]       n_state;
    logic [IDX_W-1:0]         r_col;
    logic [IDX_W-1:0]         r_row;
    logic signed [WORD_W-1:0] r_cr;
    logic signed [WORD_W-1:0] r_ci;
    logic signed [WORD_W-1:0] r_zr;
    logic signed [WORD_W-1:0] r_zi;
    logic signed [PROD_W-1:0] r_rr;
    logic signed [PROD_W-1:0] r_diff;
    logic                     r_esc;
    logic [COUNT_W-1:0]       r_count;
    logic [GREY_W-1:0]        r_grey;
    logic                     r_div_start;

    logic signed [WORD_W-1:0] w_mul_a;
    logic signed [WORD_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_nr;
    logic signed [PROD_W-1:0] w_ni;
    logic                     w_col_big;
    logic                     w_row_big;
    logic                     w_last;
    t_div_req                 w_div_req;
    t_div_rsp                 w_div_rsp;

    // Shared multiplier and grey level divider
    mpe_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_div_req.start    = r_div_start;
    assign w_div_req.count    = r_count;
    assign w_div_req.max_iter = i_cfg.max_iterations;

    mpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Multiplier operand selection per sequencer step
    always_comb begin
        unique case (r_state)
            S_CR_MUL: begin
                w_mul_a = $signed(WORD_W'(r_col));
                w_mul_b = $signed({1'b0, i_cfg.real_step});
            end
            S_CI_MUL: begin
                w_mul_a = $signed(WORD_W'(r_row));
                w_mul_b = $signed({1'b0, i_cfg.imag_step});
            end
            S_RR: begin
                w_mul_a = r_zr;
                w_mul_b = r_zr;
            end
            S_II: begin
                w_mul_a = r_zi;
                w_mul_b = r_zi;
            end
            default: begin
                w_mul_a = r_zr;
                w_mul_b = r_zi;
            end
        endcase
    end

    // Index wrap, next z terms and the iteration limit test
    assign w_col_big = (32'(r_col) >= 32'(IMAGE_DIM));
    assign w_row_big = (32'(r_row) >= 32'(IMAGE_DIM));
    assign w_nr      = r_diff >>> FRAC_BITS;
    assign w_ni      = w_prod >>> (FRAC_BITS - 1);
    assign w_last    = ((r_count + COUNT_W'(1)) == i_cfg.max_iterations);

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                if (!w_col_big && !w_row_big) begin
                    n_state = S_CR_MUL;
                end
            end
            S_CR_MUL: n_state = S_CI_MUL;
            S_CI_MUL: n_state = S_CI_ADD;
            S_CI_ADD: begin
                n_state = (i_cfg.max_iterations == '0) ? S_DONE : S_RR;
            end
            S_RR: n_state = S_II;
            S_II: n_state = S_RI;
            S_RI: n_state = S_UPD;
            S_UPD: begin
                n_state = (r_esc || w_last) ? S_DIV : S_RR;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= (r_state == S_UPD) && (n_state == S_DIV);
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_col <= i_column;
                    r_row <= i_row;
                end
            end
            S_WRAP: begin
                if (w_col_big) begin
                    r_col <= r_col - IMG_SUB;
                end
                if (w_row_big) begin
                    r_row <= r_row - IMG_SUB;
                end
            end
            S_CI_MUL: begin
                r_cr <= sat_word(WIDE_W'(i_cfg.real_origin) + WIDE_W'(w_prod));
            end
            S_CI_ADD: begin
                r_ci    <= sat_word(WIDE_W'(i_cfg.imag_origin) + WIDE_W'(w_prod));
                r_zr    <= '0;
                r_zi    <= '0;
                r_count <= '0;
                r_grey  <= '0;
            end
            S_II: begin
                r_rr <= w_prod;
            end
            S_RI: begin
                // Product now holds zi*zi; both squares are non-negative.
                r_diff <= r_rr - w_prod;
                r_esc  <= ESC_ON &&
                          (({1'b0, r_rr} + {1'b0, w_prod}) > ESC_LIMIT);
            end
            S_UPD: begin
                // Product now holds zr*zi; doubling is folded into the shift.
                if (!r_esc) begin
                    r_zr    <= sat_word(WIDE_W'(w_nr) + WIDE_W'(r_cr));
                    r_zi    <= sat_word(WIDE_W'(w_ni) + WIDE_W'(r_ci));
                    r_count <= r_count + COUNT_W'(1);
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    r_grey <= w_div_rsp.quot;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_DONE);
    assign o_res.count = r_count;
    assign o_res.grey  = r_grey;

    // An update step only runs while the count is below the limit.
    a_count_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_count < i_cfg.max_iterations))
        else $error("iteration count reached the limit inside an update step");

endmodule

`default_nettype wire

@@ rtl/mandelbrot_pixel_escape_unit.sv @@
`default_nettype none

// Mandelbrot escape-time unit: each input transaction carries a pixel column
// and row, and one output transaction returns the number of iterations of
// z = z*z + c before |z|^2 exceeds 4 (capped at max_iterations) and a grey
// level floor(count*255/max_iterations). The point c is origin + index*step
// in signed Q4.28, saturated, and indices wrap at the image size. All
// multiplications run through a single 32x32 multiplier, so one iteration
// pass steps in turn through zr*zr, zi*zi, zr*zi and the update of z. A
// point that escapes after N iterations runs N + 1 passes, because the pass
// that detects the escape also runs in full; one that runs to a limit of N
// runs N. Before the passes come the index wrap and the point c, after them
// the eight-step grey level divider and the output register; a zero limit
// skips both the passes and the divider. One pixel is in work at a time; the
// next pixel can be accepted in the cycle after the previous result moves
// into the output register, where it may wait. The registers are
// max_iterations, real_origin, imag_origin, real_step and imag_step at byte
// addresses 0, 4, 8, 12 and 16 of the APB port, and should only be written
// while no pixel is in work or waiting.
module mandelbrot_pixel_escape_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mpe_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [mpe_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mpe_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready,
    mpe_pix_if.sink                                i_pix,
    mpe_res_if.source                              o_res
);
    import mpe_pkg::*;

    t_cfg               w_cfg;
    t_result            w_res;
    logic               w_idle;
    logic               w_take;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic [GREY_W-1:0]  r_out_grey;

    mpe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mpe_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_start  (i_pix.valid && w_idle),
        .i_column (i_pix.column),
        .i_row    (i_pix.row),
        .i_take   (w_take),
        .o_idle   (w_idle),
        .o_res    (w_res)
    );

    assign i_pix.ready = w_idle;

    // Output register: loads when empty or when its transaction completes.
    assign w_take = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_res.valid) begin
            r_out_count <= w_res.count;
            r_out_grey  <= w_res.grey;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.iteration_count = r_out_count;
    assign o_res.grey_level      = r_out_grey;

    // A pixel that never iterated is black.
    a_zero_count_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_count == '0)) |-> (r_out_grey == '0))
        else $error("zero iteration count with a nonzero grey level");

    // Full white exactly when the pixel ran to the iteration limit.
    a_white_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (w_cfg.max_iterations != '0)) |->
        ((r_out_count == w_cfg.max_iterations) == (r_out_grey == GREY_MAX)))
        else $error("grey level disagrees with the iteration limit");

endmodule

`default_nettype wire
